// ----- rtl/core/bgzf_header_parser_assert.svh -----
// Assertion macros for the BGZF header parser.
// Included by the RTL modules that carry concurrent assertions; expects clk and rst in scope.
`ifndef BGZF_HEADER_PARSER_ASSERT_SVH
`define BGZF_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define BHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define BHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/bhp_pkg.sv -----
// Shared types and constants for the BGZF header parser.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package bhp_pkg;

  localparam int StatusW = 3;
  localparam int SizeW   = 17;
  localparam int XlenW   = 16;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_MAGIC   = 3'd1;
  localparam logic [StatusW-1:0] ST_XLEN    = 3'd2;
  localparam logic [StatusW-1:0] ST_BADSIZE = 3'd3;
  localparam logic [StatusW-1:0] ST_MISSING = 3'd4;

  // Header magic, byte 0 first.
  localparam logic [3:0][7:0] MAGIC = {8'd4, 8'd8, 8'd139, 8'd31};
  // Identifiers and length of the block size subfield.
  localparam logic [7:0] BC_SI1 = 8'd66;
  localparam logic [7:0] BC_SI2 = 8'd67;
  localparam logic [7:0] BC_SLEN_LO = 8'd2;
  localparam logic [7:0] BC_SLEN_HI = 8'd0;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SizeW-1:0]   total_size;
    logic [XlenW-1:0]   xfield_len;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start;
  } in_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/bhp_in_reg.sv -----
// Input register of the BGZF header parser: holds one header byte until the parser takes it.
// Depends on bhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bhp_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bhp_pkg::in_item_t in_item,
  input  wire logic            take,
  output logic                 held_valid,
  output bhp_pkg::in_item_t    held_item
);

  logic valid_next;

  // The slot is free when empty or when its byte is being consumed this cycle.
  assign in_ready   = !held_valid || take;
  assign valid_next = (in_valid && in_ready) || (held_valid && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bhp_parser.sv -----
// Byte-wise header walk: fixed header, extra subfields, block size; one result per header.
// Depends on bhp_pkg and bgzf_header_parser_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "bgzf_header_parser_assert.svh"

module bhp_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire bhp_pkg::in_item_t item,
  output logic                   res_valid,
  output bhp_pkg::result_t       res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FIXED  = 3'd1;
  localparam logic [2:0] PH_SUBHDR = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_BSIZE  = 3'd4;
  localparam logic [2:0] PH_TAIL   = 3'd5;

  localparam logic [1:0] NS_GO    = 2'd0;
  localparam logic [1:0] NS_MISS  = 2'd1;
  localparam logic [1:0] NS_SHORT = 2'd2;

  logic [2:0]  phase, phase_next, phase_e;
  logic [3:0]  byte_index, byte_index_next, idx_e;
  logic [15:0] xlen, xlen_next, xlen_new;
  logic [16:0] offset, offset_next, off4, off_slen;
  logic [7:0]  sb0, sb1, sb2, sb0_next, sb1_next, sb2_next;
  logic [15:0] skip_count, skip_count_next, tail_len, slen, bsize_full;
  logic [15:0] bsize, bsize_next;
  logic [1:0]  ns;
  logic [7:0]  b;

  // Decide whether another subfield header fits at the given offset.
  function automatic logic [1:0] next_sub(input logic [16:0] off, input logic [15:0] xl);
    logic [17:0] off_plus4;
    off_plus4 = {1'b0, off} + 18'd4;
    if (off >= {1'b0, xl}) begin
      return NS_MISS;
    end else if (off_plus4 > {2'b00, xl}) begin
      return NS_SHORT;
    end
    return NS_GO;
  endfunction

  assign b          = item.data_byte;
  assign xlen_new   = {b, xlen[7:0]};
  assign off4       = offset + 17'd4;
  assign slen       = {b, sb2};
  assign off_slen   = off4 + {1'b0, slen};
  assign bsize_full = {b, bsize[7:0]};
  assign tail_len   = xlen - offset[15:0] - 16'd2;

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    xlen_next       = xlen;
    offset_next     = offset;
    sb0_next        = sb0;
    sb1_next        = sb1;
    sb2_next        = sb2;
    skip_count_next = skip_count;
    bsize_next      = bsize;
    res_valid       = 1'b0;
    res             = '0;
    ns              = NS_GO;
    phase_e         = item.start ? PH_FIXED : phase;
    idx_e           = item.start ? 4'd0 : byte_index;
    if (fire) begin
      phase_next      = phase_e;
      byte_index_next = idx_e;
      unique case (phase_e)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_FIXED: begin
          byte_index_next = idx_e + 4'd1;
          if (idx_e < 4'd4) begin
            if (b != bhp_pkg::MAGIC[idx_e[1:0]]) begin
              res_valid  = 1'b1;
              res.status = bhp_pkg::ST_MAGIC;
              phase_next = PH_IDLE;
            end
          end else if (idx_e == 4'd10) begin
            xlen_next = {8'd0, b};
          end else if (idx_e == 4'd11) begin
            xlen_next   = xlen_new;
            offset_next = '0;
            ns          = next_sub(17'd0, xlen_new);
            if (ns == NS_GO) begin
              phase_next      = PH_SUBHDR;
              byte_index_next = '0;
            end else begin
              res_valid      = 1'b1;
              res.status     = (ns == NS_MISS) ? bhp_pkg::ST_MISSING : bhp_pkg::ST_XLEN;
              res.xfield_len = xlen_new;
              phase_next     = PH_IDLE;
            end
          end
        end
        PH_SUBHDR: begin
          byte_index_next = idx_e + 4'd1;
          unique case (idx_e[1:0])
            2'd0: sb0_next = b;
            2'd1: sb1_next = b;
            2'd2: sb2_next = b;
            default: begin
              res.xfield_len = xlen;
              if (sb0 == bhp_pkg::BC_SI1 && sb1 == bhp_pkg::BC_SI2) begin
                offset_next = off4;
                if (sb2 != bhp_pkg::BC_SLEN_LO || b != bhp_pkg::BC_SLEN_HI) begin
                  res_valid  = 1'b1;
                  res.status = bhp_pkg::ST_BADSIZE;
                  phase_next = PH_IDLE;
                end else if ({1'b0, xlen} < off4 + 17'd2) begin
                  res_valid  = 1'b1;
                  res.status = bhp_pkg::ST_XLEN;
                  phase_next = PH_IDLE;
                end else begin
                  phase_next      = PH_BSIZE;
                  byte_index_next = '0;
                end
              end else begin
                offset_next = off_slen;
                if (slen == 16'd0) begin
                  ns = next_sub(off_slen, xlen);
                  if (ns == NS_GO) begin
                    byte_index_next = '0;
                  end else begin
                    res_valid  = 1'b1;
                    res.status = (ns == NS_MISS) ? bhp_pkg::ST_MISSING : bhp_pkg::ST_XLEN;
                    phase_next = PH_IDLE;
                  end
                end else begin
                  skip_count_next = slen;
                  phase_next      = PH_SKIP;
                end
              end
            end
          endcase
        end
        PH_SKIP: begin
          skip_count_next = skip_count - 16'd1;
          if (skip_count == 16'd1) begin
            ns = next_sub(offset, xlen);
            if (ns == NS_GO) begin
              phase_next      = PH_SUBHDR;
              byte_index_next = '0;
            end else begin
              res_valid      = 1'b1;
              res.status     = (ns == NS_MISS) ? bhp_pkg::ST_MISSING : bhp_pkg::ST_XLEN;
              res.xfield_len = xlen;
              phase_next     = PH_IDLE;
            end
          end
        end
        PH_BSIZE: begin
          if (idx_e[0] == 1'b0) begin
            bsize_next      = {8'd0, b};
            byte_index_next = 4'd1;
          end else begin
            bsize_next      = bsize_full;
            skip_count_next = tail_len;
            if (tail_len == 16'd0) begin
              res_valid      = 1'b1;
              res.status     = bhp_pkg::ST_OK;
              res.total_size = {1'b0, bsize_full} + 17'd1;
              res.xfield_len = xlen;
              phase_next     = PH_IDLE;
            end else begin
              phase_next = PH_TAIL;
            end
          end
        end
        PH_TAIL: begin
          skip_count_next = skip_count - 16'd1;
          if (skip_count == 16'd1) begin
            res_valid      = 1'b1;
            res.status     = bhp_pkg::ST_OK;
            res.total_size = {1'b0, bsize} + 17'd1;
            res.xfield_len = xlen;
            phase_next     = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_index <= '0;
      xlen       <= '0;
      offset     <= '0;
      skip_count <= '0;
      bsize      <= '0;
      sb0        <= '0;
      sb1        <= '0;
      sb2        <= '0;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      xlen       <= xlen_next;
      offset     <= offset_next;
      skip_count <= skip_count_next;
      bsize      <= bsize_next;
      sb0        <= sb0_next;
      sb1        <= sb1_next;
      sb2        <= sb2_next;
    end
  end

  `BHP_ASSERT_NEXT(a_idle_after_result, fire && res_valid, phase == PH_IDLE,
                   "parser not idle after result")
  `BHP_ASSERT_NOW(a_ok_has_size, res_valid && res.status == bhp_pkg::ST_OK,
                  res.total_size != '0, "ok result with zero block size")
  `BHP_ASSERT_NOW(a_err_no_size, res_valid && res.status != bhp_pkg::ST_OK,
                  res.total_size == '0, "error result with block size")
  `BHP_ASSERT_NOW(a_magic_no_xlen, res_valid && res.status == bhp_pkg::ST_MAGIC,
                  res.xfield_len == '0, "bad magic with extra length")

endmodule

`default_nettype wire

// ----- rtl/core/bhp_out_reg.sv -----
// Result register of the BGZF header parser: holds one result until the consumer takes it.
// Depends on bhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bhp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire bhp_pkg::result_t load_res,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  can_load,
  output bhp_pkg::result_t      held_res
);

  logic valid_next;

  assign can_load   = !out_valid || out_ready;
  assign valid_next = load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_res <= load_res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bgzf_header_parser.sv -----
// BGZF block header parser, top level: input register, parser, result register.
// Depends on bhp_pkg, bhp_in_reg, bhp_parser and bhp_out_reg.
// Header bytes enter one per request on the input channel, with start_of_header marking byte 0;
// a new byte can be taken every cycle as long as the result register is free or is being
// emptied. One result request leaves per header: on the first error, or after the last byte of
// the extra field on success. The result is registered: the deciding byte passes the input
// register, then the result register, and a result still waiting in the result register holds
// it back. A raised start_of_header abandons any header in progress without a result. Bytes
// outside a header are consumed and dropped.
`timescale 1ns / 1ps
`default_nettype none

module bgzf_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_header,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [16:0]      total_size,
  output logic [15:0]      xfield_len
);

  bhp_pkg::in_item_t in_item, held_item;
  bhp_pkg::result_t  step_res, held_res;
  logic held_valid, fire, can_load, step_valid;

  assign in_item.data_byte = data_byte;
  assign in_item.start     = start_of_header;
  assign fire              = held_valid && can_load;

  bhp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .take      (fire),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  bhp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (held_item),
    .res_valid(step_valid),
    .res      (step_res)
  );

  bhp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && step_valid),
    .load_res (step_res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .can_load (can_load),
    .held_res (held_res)
  );

  assign status     = held_res.status;
  assign total_size = held_res.total_size;
  assign xfield_len = held_res.xfield_len;

endmodule

`default_nettype wire
